>>> hdl/jsu_pkg.sv
// shared types and constants for the json string unescaper
// no dependencies; used by the front, queue, back and top modules
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  CH_QUOTE  = 8'h22;
	localparam logic [7:0]  CH_BSLASH = 8'h5C;
	localparam logic [7:0]  CH_SLASH  = 8'h2F;
	localparam logic [7:0]  CH_B      = 8'h62;
	localparam logic [7:0]  CH_F      = 8'h66;
	localparam logic [7:0]  CH_N      = 8'h6E;
	localparam logic [7:0]  CH_R      = 8'h72;
	localparam logic [7:0]  CH_T      = 8'h74;
	localparam logic [7:0]  CH_U      = 8'h75;
	localparam logic [5:0]  SUR_HIGH_TOP = 6'b110110;
	localparam logic [5:0]  SUR_LOW_TOP  = 6'b110111;
	localparam logic [10:0] PLANE_OFFSET = 11'h040;

	typedef enum logic [3:0] {
		PH_NORMAL  = 4'd0,
		PH_ESC     = 4'd1,
		PH_HEX1    = 4'd2,
		PH_HEX2    = 4'd3,
		PH_HEX3    = 4'd4,
		PH_HEX4    = 4'd5,
		PH_PAIR_BS = 4'd6,
		PH_PAIR_U  = 4'd7,
		PH_LOW1    = 4'd8,
		PH_LOW2    = 4'd9,
		PH_LOW3    = 4'd10,
		PH_LOW4    = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_BAD_ESC = 3'd1,
		ERR_BAD_HEX = 3'd2,
		ERR_BAD_SUR = 3'd3,
		ERR_TRUNC   = 3'd4
	} err_t;

	// one accepted item's worth of results
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      cnt;
		logic            is_data;
		err_t            code;
		logic            last;
	} job_t;

endpackage

>>> hdl/jsu_front.sv
// front end: accepts escaped bytes, tracks escape phase and builds at most one job per item
// depends on jsu_pkg
module jsu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            push,
	output logic            full,
	input  logic            q_full,
	output logic            job_valid,
	output jsu_pkg::job_t   job
);

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt;
	} utf8_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, b[3:0]};
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t u;
		u.bytes = '0;
		if (cp[20:7] == 14'd0) begin
			u.bytes[0] = {1'b0, cp[6:0]};
			u.cnt = 2'd0;
		end else if (cp[20:11] == 10'd0) begin
			u.bytes[0] = {3'b110, cp[10:6]};
			u.bytes[1] = {2'b10, cp[5:0]};
			u.cnt = 2'd1;
		end else if (cp[20:16] == 5'd0) begin
			u.bytes[0] = {4'b1110, cp[15:12]};
			u.bytes[1] = {2'b10, cp[11:6]};
			u.bytes[2] = {2'b10, cp[5:0]};
			u.cnt = 2'd2;
		end else begin
			u.bytes[0] = {5'b11110, cp[20:18]};
			u.bytes[1] = {2'b10, cp[17:12]};
			u.bytes[2] = {2'b10, cp[11:6]};
			u.bytes[3] = {2'b10, cp[5:0]};
			u.cnt = 2'd3;
		end
		return u;
	endfunction

	jsu_pkg::phase_t phase_q, phase_d, ph_go;
	logic [15:0]     hex_q, hex_d;
	logic [9:0]      high_q, high_d;
	logic            latched_q, latched_d;

	logic            accept;
	logic [4:0]      dig;
	logic [15:0]     acc;
	logic            is_hi, is_lo;
	jsu_pkg::err_t   err_c;
	logic            trunc;
	logic            emit_char, emit_cp;
	logic [7:0]      char_c;
	logic [20:0]     cp_c;
	logic            clr_hex, ld_hex, ld_high;
	utf8_t           utf;
	logic            has_result;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign dig    = hex_digit(in_byte);
	assign acc    = {hex_q[11:0], dig[3:0]};
	assign is_hi  = (acc[15:10] == jsu_pkg::SUR_HIGH_TOP);
	assign is_lo  = (acc[15:10] == jsu_pkg::SUR_LOW_TOP);

	// decode of the byte against the current phase
	always_comb begin
		err_c     = jsu_pkg::ERR_NONE;
		ph_go     = jsu_pkg::PH_NORMAL;
		emit_char = 1'b0;
		emit_cp   = 1'b0;
		char_c    = in_byte;
		cp_c      = {5'd0, acc};
		clr_hex   = 1'b0;
		ld_hex    = 1'b0;
		ld_high   = 1'b0;
		case (phase_q)
			jsu_pkg::PH_ESC: begin
				case (in_byte)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: emit_char = 1'b1;
					jsu_pkg::CH_B: begin
						emit_char = 1'b1;
						char_c = 8'h08;
					end
					jsu_pkg::CH_F: begin
						emit_char = 1'b1;
						char_c = 8'h0C;
					end
					jsu_pkg::CH_N: begin
						emit_char = 1'b1;
						char_c = 8'h0A;
					end
					jsu_pkg::CH_R: begin
						emit_char = 1'b1;
						char_c = 8'h0D;
					end
					jsu_pkg::CH_T: begin
						emit_char = 1'b1;
						char_c = 8'h09;
					end
					jsu_pkg::CH_U: begin
						ph_go = jsu_pkg::PH_HEX1;
						clr_hex = 1'b1;
					end
					default: err_c = jsu_pkg::ERR_BAD_ESC;
				endcase
			end
			jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4,
			jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2, jsu_pkg::PH_LOW3, jsu_pkg::PH_LOW4: begin
				if (!dig[4]) begin
					err_c = jsu_pkg::ERR_BAD_HEX;
				end else begin
					ld_hex = 1'b1;
					case (phase_q)
						jsu_pkg::PH_HEX1: ph_go = jsu_pkg::PH_HEX2;
						jsu_pkg::PH_HEX2: ph_go = jsu_pkg::PH_HEX3;
						jsu_pkg::PH_HEX3: ph_go = jsu_pkg::PH_HEX4;
						jsu_pkg::PH_LOW1: ph_go = jsu_pkg::PH_LOW2;
						jsu_pkg::PH_LOW2: ph_go = jsu_pkg::PH_LOW3;
						jsu_pkg::PH_LOW3: ph_go = jsu_pkg::PH_LOW4;
						jsu_pkg::PH_HEX4: begin
							if (is_hi) begin
								ld_high = 1'b1;
								ph_go = jsu_pkg::PH_PAIR_BS;
							end else if (is_lo) begin
								err_c = jsu_pkg::ERR_BAD_SUR;
							end else begin
								emit_cp = 1'b1;
							end
						end
						default: begin
							if (is_lo) begin
								emit_cp = 1'b1;
								cp_c = {{1'b0, high_q} + jsu_pkg::PLANE_OFFSET, acc[9:0]};
							end else begin
								err_c = jsu_pkg::ERR_BAD_SUR;
							end
						end
					endcase
				end
			end
			jsu_pkg::PH_PAIR_BS: begin
				if (in_byte == jsu_pkg::CH_BSLASH) begin
					ph_go = jsu_pkg::PH_PAIR_U;
				end else begin
					err_c = jsu_pkg::ERR_BAD_SUR;
				end
			end
			jsu_pkg::PH_PAIR_U: begin
				if (in_byte == jsu_pkg::CH_U) begin
					ph_go = jsu_pkg::PH_LOW1;
					clr_hex = 1'b1;
				end else begin
					err_c = jsu_pkg::ERR_BAD_SUR;
				end
			end
			default: begin
				if (in_byte == jsu_pkg::CH_BSLASH) begin
					ph_go = jsu_pkg::PH_ESC;
				end else begin
					emit_char = 1'b1;
				end
			end
		endcase
	end

	assign trunc = in_last && (ph_go != jsu_pkg::PH_NORMAL) && (err_c == jsu_pkg::ERR_NONE);

	// next state
	always_comb begin
		phase_d   = phase_q;
		hex_d     = hex_q;
		high_d    = high_q;
		latched_d = latched_q;
		if (accept) begin
			if (in_last) begin
				phase_d   = jsu_pkg::PH_NORMAL;
				hex_d     = '0;
				high_d    = '0;
				latched_d = 1'b0;
			end else if (!latched_q) begin
				phase_d   = (err_c != jsu_pkg::ERR_NONE) ? jsu_pkg::PH_NORMAL : ph_go;
				latched_d = (err_c != jsu_pkg::ERR_NONE);
				if (clr_hex) begin
					hex_d = '0;
				end else if (ld_hex) begin
					hex_d = acc;
				end
				if (ld_high) begin
					high_d = acc[9:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jsu_pkg::PH_NORMAL;
			hex_q     <= '0;
			high_q    <= '0;
			latched_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			hex_q     <= hex_d;
			high_q    <= high_d;
			latched_q <= latched_d;
		end
	end

	// job for the queue
	always_comb begin
		utf         = utf8_enc(cp_c);
		job.data    = '0;
		job.cnt     = 2'd0;
		job.is_data = 1'b0;
		job.code    = jsu_pkg::ERR_NONE;
		job.last    = in_last;
		has_result  = 1'b0;
		if (latched_q) begin
			has_result = in_last;
		end else if (err_c != jsu_pkg::ERR_NONE) begin
			has_result = 1'b1;
			job.code = err_c;
		end else if (trunc) begin
			has_result = 1'b1;
			job.code = jsu_pkg::ERR_TRUNC;
		end else if (emit_char) begin
			has_result = 1'b1;
			job.is_data = 1'b1;
			job.data[0] = char_c;
		end else if (emit_cp) begin
			has_result = 1'b1;
			job.is_data = 1'b1;
			job.data = utf.bytes;
			job.cnt = utf.cnt;
		end else begin
			has_result = in_last;
		end
	end

	assign job_valid = accept && has_result;

endmodule

>>> hdl/jsu_queue.sv
// short job queue between front and back ends
// depends on jsu_pkg
module jsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  jsu_pkg::job_t wr_job,
	output logic          q_full,
	input  logic          rd_en,
	output jsu_pkg::job_t rd_job,
	output logic          q_empty
);

	jsu_pkg::job_t                mem_q [jsu_pkg::QUEUE_DEPTH];
	logic [jsu_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [jsu_pkg::QCNT_W-1:0]   count_q;
	logic                         do_wr, do_rd;

	assign q_full  = (count_q == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/jsu_back.sv
// back end: walks each job one result at a time into the output register
// depends on jsu_pkg
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::job_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          run_last,
	output logic          string_end,
	output logic [2:0]    error_code,
	output logic          empty,
	input  logic          pop
);

	logic [1:0]    idx_q;
	logic          out_valid_q;
	logic [7:0]    byte_q;
	logic          bval_q, run_last_q, str_end_q;
	jsu_pkg::err_t code_q;
	logic          load, take, fin;

	assign load  = !out_valid_q || pop;
	assign take  = load && !q_empty;
	assign fin   = (idx_q == head.cnt);
	assign q_pop = take && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (take) begin
				idx_q <= fin ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q     <= head.is_data ? head.data[idx_q] : 8'd0;
			bval_q     <= head.is_data;
			code_q     <= head.is_data ? jsu_pkg::ERR_NONE : head.code;
			run_last_q <= fin;
			str_end_q  <= fin && head.last;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = byte_q;
	assign byte_valid = bval_q;
	assign run_last   = run_last_q;
	assign string_end = str_end_q;
	assign error_code = code_q;

endmodule

>>> hdl/json_string_unescape_utf8.sv
// json string unescaper, \uXXXX escapes and surrogate pairs to utf-8 bytes
// path: an accepted item's job is written to the queue, and its first result is then loaded
//   into the output register once the queue and the output register hold nothing older
// throughput: one item per cycle unless full, one result per cycle out of the output register if popped;
//   a four-byte code point holds the back end for four results, the four-job queue absorbs it
// reset: arst_n clears phase, queue pointers and output valid at once
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end,
	output logic [2:0] error_code,
	output logic       empty,
	input  logic       pop
);

	jsu_pkg::job_t wr_job, rd_job;
	logic          wr_en, q_full, q_empty, rd_en;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (push),
		.full      (full),
		.q_full    (q_full),
		.job_valid (wr_en),
		.job       (wr_job)
	);

	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_job  (wr_job),
		.q_full  (q_full),
		.rd_en   (rd_en),
		.rd_job  (rd_job),
		.q_empty (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_job),
		.q_empty    (q_empty),
		.q_pop      (rd_en),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.error_code (error_code),
		.empty      (empty),
		.pop        (pop)
	);

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_end) |-> run_last)
		else $error("string end without run last");

	a_data_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && byte_valid) |-> (error_code == jsu_pkg::ERR_NONE))
		else $error("data result carries an error code");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (out_byte == 8'd0))
		else $error("non-data result with nonzero byte");

	a_queue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!wr_en || !q_full) && (!rd_en || !q_empty))
		else $error("queue overrun or underrun");

endmodule

>>> bench/tb_top.sv
// self-checking bench for json_string_unescape_utf8: escaped string bytes in, utf-8 items out
// predicts each result item in-bench and checks every field; depends on jsu_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
		err_t       error_code;
	} utf8_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] in_byte = 8'd0;
	logic       in_last = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;
	logic [2:0] error_code;
	logic       empty;

	// predictor state
	phase_t      esc_ph = PH_NORMAL;
	logic [15:0] hex_acc = 16'd0;
	logic [9:0]  hi_half = 10'd0;
	logic        err_latch = 1'b0;

	utf8_res_t   step_res[$];
	utf8_res_t   pending_bytes[$];
	logic [7:0]  text_buf[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	json_string_unescape_utf8 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.push       (push),
		.full       (full),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.error_code (error_code),
		.empty      (empty),
		.pop        (pop)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int hex_val(logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
		if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
		if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
		return -1;
	endfunction

	function automatic void add_res(logic [7:0] ob, logic bv, err_t ec);
		utf8_res_t r;
		r.out_byte   = ob;
		r.byte_valid = bv;
		r.run_last   = 1'b0;
		r.string_end = 1'b0;
		r.error_code = ec;
		step_res.push_back(r);
	endfunction

	function automatic void add_utf8(logic [20:0] cp);
		if (cp <= 21'h7F) begin
			add_res(cp[7:0], 1'b1, ERR_NONE);
		end else if (cp <= 21'h7FF) begin
			add_res({3'b110, cp[10:6]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
		end else if (cp <= 21'hFFFF) begin
			add_res({4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
		end else begin
			add_res({5'b11110, cp[20:18]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[17:12]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
			add_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
		end
	endfunction

	task automatic unescape_step(input logic [7:0] b, input logic last);
		err_t        err;
		phase_t      ph;
		int          d;
		logic [15:0] acc;
		logic [20:0] cp;
		logic [7:0]  c;
		logic        simple;
		step_res.delete();
		err = ERR_NONE;
		if (!err_latch) begin
			ph = esc_ph;
			if (ph == PH_ESC) begin
				simple = 1'b1;
				c = b;
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
					CH_B: c = 8'h08;
					CH_F: c = 8'h0C;
					CH_N: c = 8'h0A;
					CH_R: c = 8'h0D;
					CH_T: c = 8'h09;
					default: simple = 1'b0;
				endcase
				if (simple) begin
					add_res(c, 1'b1, ERR_NONE);
					esc_ph = PH_NORMAL;
				end else if (b == CH_U) begin
					hex_acc = 16'd0;
					esc_ph = PH_HEX1;
				end else begin
					err = ERR_BAD_ESC;
				end
			end else if ((ph >= PH_HEX1 && ph <= PH_HEX4) || (ph >= PH_LOW1 && ph <= PH_LOW4)) begin
				d = hex_val(b);
				if (d < 0) begin
					err = ERR_BAD_HEX;
				end else begin
					acc = {hex_acc[11:0], 4'(d)};
					hex_acc = acc;
					if (ph == PH_HEX4) begin
						if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
							hi_half = acc[9:0];
							esc_ph = PH_PAIR_BS;
						end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
							err = ERR_BAD_SUR;
						end else begin
							add_utf8({5'd0, acc});
							esc_ph = PH_NORMAL;
						end
					end else if (ph == PH_LOW4) begin
						if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
							cp = {1'b0, hi_half, 10'd0} + {11'd0, acc[9:0]} + 21'h10000;
							add_utf8(cp);
							esc_ph = PH_NORMAL;
						end else begin
							err = ERR_BAD_SUR;
						end
					end else begin
						esc_ph = phase_t'(ph + 4'd1);
					end
				end
			end else if (ph == PH_PAIR_BS) begin
				if (b == CH_BSLASH) esc_ph = PH_PAIR_U;
				else err = ERR_BAD_SUR;
			end else if (ph == PH_PAIR_U) begin
				if (b == CH_U) begin
					hex_acc = 16'd0;
					esc_ph = PH_LOW1;
				end else begin
					err = ERR_BAD_SUR;
				end
			end else begin
				if (b == CH_BSLASH) begin
					esc_ph = PH_ESC;
				end else begin
					add_res(b, 1'b1, ERR_NONE);
					esc_ph = PH_NORMAL;
				end
			end

			if (err != ERR_NONE) begin
				add_res(8'd0, 1'b0, err);
				err_latch = 1'b1;
				esc_ph = PH_NORMAL;
			end else if (last && esc_ph != PH_NORMAL) begin
				add_res(8'd0, 1'b0, ERR_TRUNC);
				err_latch = 1'b1;
			end
		end

		if (last && step_res.size() == 0) add_res(8'd0, 1'b0, ERR_NONE);
		if (step_res.size() > 0) begin
			step_res[step_res.size() - 1].run_last = 1'b1;
			if (last) step_res[step_res.size() - 1].string_end = 1'b1;
		end
		foreach (step_res[i]) pending_bytes.push_back(step_res[i]);
		if (last) begin
			esc_ph = PH_NORMAL;
			hex_acc = 16'd0;
			hi_half = 10'd0;
			err_latch = 1'b0;
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		in_byte <= b;
		in_last <= last;
		push <= 1'b1;
		do @(posedge clk); while (full);
		unescape_step(b, last);
	endtask

	task automatic send_text();
		foreach (text_buf[i]) send_item(text_buf[i], i == text_buf.size() - 1);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'd0, n};
		return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
	endfunction

	function automatic logic is_esc_letter(logic [7:0] b);
		case (b)
			CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
		return b;
	endfunction

	function automatic void add_hex4(logic [15:0] v);
		text_buf.push_back(CH_BSLASH);
		text_buf.push_back(CH_U);
		for (int i = 3; i >= 0; i--) text_buf.push_back(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void add_high();
		add_hex4(16'hD800 | 16'($urandom_range(1023)));
	endfunction

	function automatic void add_digits(int k);
		for (int i = 0; i < k; i++) text_buf.push_back(hex_char(4'($urandom_range(15))));
	endfunction

	function automatic void add_token();
		int          r;
		logic [7:0]  b;
		logic [15:0] v;
		r = $urandom_range(99);
		if (r < 30) begin
			do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
			text_buf.push_back(b);
		end else if (r < 50) begin
			text_buf.push_back(CH_BSLASH);
			case ($urandom_range(7))
				0: text_buf.push_back(CH_QUOTE);
				1: text_buf.push_back(CH_BSLASH);
				2: text_buf.push_back(CH_SLASH);
				3: text_buf.push_back(CH_B);
				4: text_buf.push_back(CH_F);
				5: text_buf.push_back(CH_N);
				6: text_buf.push_back(CH_R);
				default: text_buf.push_back(CH_T);
			endcase
		end else if (r < 70) begin
			case ($urandom_range(3))
				0: v = 16'($urandom_range(16'h7F));
				1: v = 16'($urandom_range(16'h7FF, 16'h80));
				2: v = 16'($urandom_range(16'hD7FF, 16'h800));
				default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
			endcase
			add_hex4(v);
		end else if (r < 85) begin
			add_high();
			add_hex4(16'hDC00 | 16'($urandom_range(1023)));
		end else begin
			case ($urandom_range(6))
				0: begin
					do b = 8'($urandom_range(255)); while (is_esc_letter(b));
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(b);
				end
				1: begin
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(CH_U);
					add_digits($urandom_range(3));
					text_buf.push_back(non_hex_byte());
				end
				2: add_hex4(16'hDC00 | 16'($urandom_range(1023)));
				3: begin
					add_high();
					do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
					text_buf.push_back(b);
				end
				4: begin
					add_high();
					text_buf.push_back(CH_BSLASH);
					do b = 8'($urandom_range(255)); while (b == CH_U);
					text_buf.push_back(b);
				end
				5: begin
					add_high();
					do v = 16'($urandom_range(16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
					add_hex4(v);
				end
				default: begin
					add_high();
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(CH_U);
					add_digits($urandom_range(3));
					text_buf.push_back(non_hex_byte());
				end
			endcase
		end
	endfunction

	// string cut off inside an escape
	function automatic void add_partial();
		case ($urandom_range(3))
			0: text_buf.push_back(CH_BSLASH);
			1: begin
				text_buf.push_back(CH_BSLASH);
				text_buf.push_back(CH_U);
				add_digits($urandom_range(3));
			end
			2: add_high();
			default: begin
				add_high();
				text_buf.push_back(CH_BSLASH);
				if ($urandom_range(1)) begin
					text_buf.push_back(CH_U);
					add_digits($urandom_range(3));
				end
			end
		endcase
	endfunction

	task automatic test_plain_extremes();
		text_buf = '{8'hFF, 8'h00};
		send_text();
	endtask

	task automatic test_bad_escape();
		text_buf = '{CH_BSLASH, 8'h71, 8'h41};
		send_text();
	endtask

	task automatic test_max_pair();
		text_buf = '{CH_BSLASH, CH_U, 8'h44, 8'h42, 8'h46, 8'h46,
			CH_BSLASH, CH_U, 8'h64, 8'h66, 8'h66, 8'h66};
		send_text();
	endtask

	task automatic test_truncation();
		text_buf = '{CH_BSLASH, CH_U, 8'h30};
		send_text();
		text_buf = '{CH_BSLASH};
		send_text();
	endtask

	task automatic test_bad_hex();
		text_buf = '{CH_BSLASH, CH_U, 8'h67, 8'h78};
		send_text();
	endtask

	task automatic test_random_strings(input int target);
		int sent;
		sent = 0;
		while (sent < target) begin
			text_buf.delete();
			repeat ($urandom_range(1, 5)) add_token();
			if ($urandom_range(9) == 0) add_partial();
			sent += text_buf.size();
			send_text();
		end
	endtask

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s expected %h got %h", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	always @(negedge clk) pop <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		utf8_res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected item out_byte %h error_code %0d", out_byte, error_code);
				fail_cnt++;
			end else begin
				exp_r = pending_bytes.pop_front();
				check_field("out_byte", exp_r.out_byte, out_byte);
				check_field("byte_valid", 8'(exp_r.byte_valid), 8'(byte_valid));
				check_field("run_last", 8'(exp_r.run_last), 8'(run_last));
				check_field("string_end", 8'(exp_r.string_end), 8'(string_end));
				check_field("error_code", 8'(exp_r.error_code), 8'(error_code));
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 35;
		rx_idle_pct = 68;
		test_plain_extremes();
		test_bad_escape();
		test_max_pair();
		test_truncation();
		test_bad_hex();
		test_random_strings(127);

		tx_idle_pct = 68;
		rx_idle_pct = 35;
		test_random_strings(127);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_strings(126);

		@(negedge clk);
		push <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
